>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the base64 encoder RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/b64enc_pkg.sv
// ---------------------------------------------------------------------------
// Base64 encoder package
// Character bundle type, alphabet mapping, group phase and queue constants.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package b64enc_pkg;

   localparam logic [6:0] PAD_CHAR = 7'h3D;
   localparam int B64ENC_QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      PHASE_0 = 2'd0,
      PHASE_1 = 2'd1,
      PHASE_2 = 2'd2
   } phase_type;

   // up to four characters produced by one byte
   typedef struct packed {
      logic [3:0][6:0] chars;
      logic [1:0]      last_idx;
      logic            final_flag;
   } bundle_type;

   function automatic logic [6:0] b64_symbol(input logic [5:0] v);
      logic [6:0] ch;
      if (v < 6'd26) begin
         ch = 7'(v) + 7'd65;
      end else if (v < 6'd52) begin
         ch = 7'(v - 6'd26) + 7'd97;
      end else if (v < 6'd62) begin
         ch = 7'(v - 6'd52) + 7'd48;
      end else if (v == 6'd62) begin
         ch = 7'h2B;
      end else begin
         ch = 7'h2F;
      end
      return ch;
   endfunction

endpackage

>>> rtl/b64enc_if.sv
// ---------------------------------------------------------------------------
// Base64 encoder channels
// Valid/ready byte request channel and character response channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface b64enc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_message;

   modport source (output valid, output data_byte, output end_of_message, input ready);
   modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface b64enc_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] code_char;
   logic       final_char;

   modport source (output valid, output code_char, output final_char, input ready);
   modport sink   (input valid, input code_char, input final_char, output ready);
endinterface

>>> rtl/b64enc_front.sv
// ---------------------------------------------------------------------------
// Base64 encoder front end
// Accepts bytes, tracks the group phase and builds each byte's characters.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module b64enc_front
   import b64enc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   b64enc_req_if.sink       req_chan,
   output logic             push_valid,
   input  logic             push_ready,
   output bundle_type       push_data
);

   phase_type  phase_ff, phase_in;
   logic [3:0] carry_ff, carry_in;
   logic       take;

   assign req_chan.ready = push_ready;
   assign push_valid     = req_chan.valid;
   assign take           = req_chan.valid && push_ready;

   // next state
   always_comb begin
      phase_in = PHASE_0;
      carry_in = '0;
      unique case (phase_ff)
         PHASE_1: begin
            if (!req_chan.end_of_message) begin
               phase_in = PHASE_2;
               carry_in = req_chan.data_byte[3:0];
            end
         end
         PHASE_2: begin
            phase_in = PHASE_0;
            carry_in = '0;
         end
         default: begin
            if (!req_chan.end_of_message) begin
               phase_in = PHASE_1;
               carry_in = {2'b00, req_chan.data_byte[1:0]};
            end
         end
      endcase
   end

   // characters for the current byte
   always_comb begin
      push_data            = '0;
      push_data.final_flag = req_chan.end_of_message;
      unique case (phase_ff)
         PHASE_1: begin
            push_data.chars[0] = b64_symbol({carry_ff[1:0], req_chan.data_byte[7:4]});
            if (req_chan.end_of_message) begin
               push_data.chars[1] = b64_symbol({req_chan.data_byte[3:0], 2'b00});
               push_data.chars[2] = PAD_CHAR;
               push_data.last_idx = 2'd2;
            end
         end
         PHASE_2: begin
            push_data.chars[0] = b64_symbol({carry_ff, req_chan.data_byte[7:6]});
            push_data.chars[1] = b64_symbol(req_chan.data_byte[5:0]);
            push_data.last_idx = 2'd1;
         end
         default: begin
            push_data.chars[0] = b64_symbol(req_chan.data_byte[7:2]);
            if (req_chan.end_of_message) begin
               push_data.chars[1] = b64_symbol({req_chan.data_byte[1:0], 4'b0000});
               push_data.chars[2] = PAD_CHAR;
               push_data.chars[3] = PAD_CHAR;
               push_data.last_idx = 2'd3;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_0;
         carry_ff <= '0;
      end else if (take) begin
         phase_ff <= phase_in;
         carry_ff <= carry_in;
      end
   end

endmodule

>>> rtl/b64enc_queue.sv
// ---------------------------------------------------------------------------
// Base64 encoder bundle queue
// Small circular queue of character bundles between front and back ends.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module b64enc_queue
   import b64enc_pkg::*;
#(
   parameter int DEPTH = B64ENC_QUEUE_DEPTH   // two or more
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push_valid,
   output logic       push_ready,
   input  bundle_type push_data,
   output logic       pop_valid,
   input  logic       pop_ready,
   output bundle_type pop_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   bundle_type       storage_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = storage_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         storage_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/b64enc_back.sv
// ---------------------------------------------------------------------------
// Base64 encoder back end
// Holds one bundle and hands its characters out one transfer at a time.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module b64enc_back
   import b64enc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        pop_valid,
   output logic        pop_ready,
   input  bundle_type  pop_data,
   b64enc_rsp_if.source rsp_chan
);

   bundle_type bundle_ff;
   logic       busy_ff, busy_in;
   logic [1:0] idx_ff, idx_in;
   logic       at_last, sent, load;

   assign at_last   = (idx_ff == bundle_ff.last_idx);
   assign sent      = busy_ff && rsp_chan.ready;
   // take the next bundle as soon as the held one has gone
   assign pop_ready = !busy_ff || (sent && at_last);
   assign load      = pop_valid && pop_ready;

   assign rsp_chan.valid      = busy_ff;
   assign rsp_chan.code_char  = bundle_ff.chars[idx_ff];
   assign rsp_chan.final_char = bundle_ff.final_flag && at_last;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (sent) begin
         if (at_last) begin
            busy_in = 1'b0;
            idx_in  = '0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bundle_ff <= pop_data;
      end
   end

endmodule

>>> rtl/base64_stream_encoder.sv
// ---------------------------------------------------------------------------
// Base64 stream encoder
// Byte stream in, standard base64 characters with '=' padding out.
// ---------------------------------------------------------------------------
//  channel    dir  payload                       transfer
//  req_chan   in   data_byte[7:0], end_of_message valid && ready
//  rsp_chan   out  code_char[6:0], final_char     valid && ready
//
//  A byte is taken in any cycle the bundle queue has room; it yields 1 to 4
//  characters, sent one per cycle while the receiver is ready, so the response
//  channel sets the pace. The first character of a byte can transfer once the
//  byte has passed the queue storage and the back end's bundle register.
//  Synchronous reset clears the group phase, the queue and the back end.
//  Either side may stall; the queue decouples them.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module base64_stream_encoder
   import b64enc_pkg::*;
#(
   parameter int QUEUE_DEPTH = B64ENC_QUEUE_DEPTH
)
(
   input  logic         clock,
   input  logic         reset,
   b64enc_req_if.sink   req_chan,
   b64enc_rsp_if.source rsp_chan
);

   logic       push_valid, push_ready;
   bundle_type push_data;
   logic       q_valid, q_ready;
   bundle_type q_data;

   b64enc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   b64enc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   b64enc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (q_valid),
      .pop_ready (q_ready),
      .pop_data  (q_data),
      .rsp_chan  (rsp_chan)
   );

   `ASSERT_IMPLIES(a_idle_accepts, clock, reset, !q_valid && !rsp_chan.valid, req_chan.ready)
   `ASSERT_IMPLIES(a_full_not_empty, clock, reset, !req_chan.ready, q_valid)
   `ASSERT_NEXT(a_pop_drives_rsp, clock, reset, q_valid && q_ready, rsp_chan.valid)

endmodule

>>> bench/b64_char_checker.sv
// ---------------------------------------------------------------------------
// Base64 character checker
// Watches the byte and character channels, predicts the encoded characters
// of every accepted byte and compares each character transfer in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module b64_char_checker
   import b64enc_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   b64enc_req_if req,
   b64enc_rsp_if rsp,
   output int    mismatch_count,
   output int    pending_chars
);

   localparam logic [8*64-1:0] ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef struct packed {
      logic [6:0] code;
      logic       last;
   } enc_char_type;

   enc_char_type expected_chars[$];
   enc_char_type oldest;
   phase_type    group_phase;
   logic [3:0]   held_bits;

   initial begin
      mismatch_count = 0;
      pending_chars  = 0;
      group_phase    = PHASE_0;
      held_bits      = 4'd0;
   end

   function automatic logic [6:0] sextet_char(input logic [5:0] v);
      return ALPHABET[8 * (63 - int'(v)) +: 7];
   endfunction

   task automatic encode_byte(input logic [7:0] data, input logic eom);
      logic [6:0] codes[4];
      int         n;
      n = 0;
      case (group_phase)
         PHASE_1: begin
            codes[0] = sextet_char({held_bits[1:0], data[7:4]});
            n = 1;
            if (eom) begin
               codes[1] = sextet_char({data[3:0], 2'b00});
               codes[2] = PAD_CHAR;
               n = 3;
            end else begin
               held_bits   = data[3:0];
               group_phase = PHASE_2;
            end
         end
         PHASE_2: begin
            codes[0] = sextet_char({held_bits, data[7:6]});
            codes[1] = sextet_char(data[5:0]);
            n = 2;
            held_bits   = 4'd0;
            group_phase = PHASE_0;
         end
         default: begin
            codes[0] = sextet_char(data[7:2]);
            n = 1;
            if (eom) begin
               codes[1] = sextet_char({data[1:0], 4'b0000});
               codes[2] = PAD_CHAR;
               codes[3] = PAD_CHAR;
               n = 4;
            end else begin
               held_bits   = {2'b00, data[1:0]};
               group_phase = PHASE_1;
            end
         end
      endcase
      if (eom) begin
         held_bits   = 4'd0;
         group_phase = PHASE_0;
      end
      for (int i = 0; i < n; i++) begin
         expected_chars.push_back('{codes[i], eom && (i == n - 1)});
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_chars.delete();
         group_phase = PHASE_0;
         held_bits   = 4'd0;
      end else begin
         // characters trail their byte through the queue and the back end's register, so check before predicting
         if (rsp.valid && rsp.ready) begin
            if (expected_chars.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: unexpected char 0x%02h final %0b", $realtime,
                           rsp.code_char, rsp.final_char);
               end
            end else begin
               oldest = expected_chars.pop_front();
               if (rsp.code_char !== oldest.code || rsp.final_char !== oldest.last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: char expected 0x%02h final %0b, got 0x%02h final %0b",
                              $realtime, oldest.code, oldest.last,
                              rsp.code_char, rsp.final_char);
                  end
               end
            end
         end
         if (req.valid && req.ready) begin
            encode_byte(req.data_byte, req.end_of_message);
         end
      end
      pending_chars = expected_chars.size();
   end

endmodule

>>> bench/tb_top.sv
// ---------------------------------------------------------------------------
// Base64 stream encoder testbench
// Sends directed and random byte messages with random gaps and receiver
// stalls; the checker beside the encoder predicts and compares characters.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_ITEMS = 350;
   localparam int HOLD_CYCLES  = 150;
   localparam int DIR_COUNT    = 20;

   // {end_of_message, data_byte}; first entry sits at the top index
   localparam logic [DIR_COUNT-1:0][8:0] DIRECTED = {
      9'h100,
      9'h1FF,
      9'h000, 9'h1FF,
      9'h0FF, 9'h000, 9'h1FF,
      9'h0FB, 9'h0EF, 9'h0BE, 9'h100,
      9'h0FF, 9'h0FF, 9'h0FF, 9'h1FF,
      9'h04D, 9'h161,
      9'h04D, 9'h061, 9'h16E
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic hold_req = 1'b0;
   logic no_idle = 1'b0;
   int   hold_left = 0;
   int   cycle_count = 0;
   int   mismatches;
   int   pending;
   int   sent;
   int   msg_len;
   int   pick;

   b64enc_req_if req();
   b64enc_rsp_if rsp();

   base64_stream_encoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp)
   );

   b64_char_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req            (req),
      .rsp            (rsp),
      .mismatch_count (mismatches),
      .pending_chars  (pending)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // receiver: random stalls, a quiet stretch, and one long hold-off
   always @(negedge clock) begin
      if (hold_req) begin
         hold_left = HOLD_CYCLES;
         hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp.ready <= 1'b0;
      end else if (no_idle) begin
         rsp.ready <= 1'b1;
      end else begin
         rsp.ready <= ($urandom_range(0, 99) >= 16);
      end
   end

   task automatic send_byte(input logic [7:0] data, input logic eom);
      req.valid          <= 1'b1;
      req.data_byte      <= data;
      req.end_of_message <= eom;
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
   endtask

   task automatic idle_cycles(input int n);
      req.valid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic drain_chars();
      req.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   initial begin
      req.valid          = 1'b0;
      req.data_byte      = 8'd0;
      req.end_of_message = 1'b0;
      rsp.ready          = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = DIR_COUNT - 1; i >= 0; i--) begin
         send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
      end
      drain_chars();

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            msg_len = $urandom_range(1, 6);
         end else if (pick < 90) begin
            msg_len = $urandom_range(7, 20);
         end else begin
            msg_len = $urandom_range(21, 40);
         end
         for (int j = 0; j < msg_len; j++) begin
            if (sent == 100) no_idle = 1'b1;
            if (sent == 180) no_idle = 1'b0;
            if (sent == 240) hold_req = 1'b1;
            if (sent == 300) drain_chars();
            if (!no_idle && $urandom_range(0, 99) < 16) begin
               idle_cycles($urandom_range(1, 2));
            end
            send_byte(8'($urandom_range(0, 255)), j == msg_len - 1);
            sent++;
         end
      end

      drain_chars();
      repeat (8) @(negedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/b64enc_pkg.sv
rtl/b64enc_if.sv
rtl/b64enc_front.sv
rtl/b64enc_queue.sv
rtl/b64enc_back.sv
rtl/base64_stream_encoder.sv
bench/b64_char_checker.sv
bench/tb_top.sv
